### rtl/nsps_pkg.sv
package nsps_pkg;

  localparam int SAMPLE_W     = 12;
  localparam int PHASE_W      = 16;
  localparam int AMP_W        = 13;
  localparam int BIAS_W       = 12;
  localparam int SUM_W        = 16;
  localparam int ACC_W        = 32;
  localparam int ROM_W        = 16;
  localparam int ABS_W        = 31;
  localparam int SQ_W         = 2 * ABS_W;
  localparam int ROOT_W       = 64;
  localparam int CX_W         = 50;
  localparam int Z_W          = 32;
  localparam int QUO_W        = 17;
  localparam int ITER_W       = 5;
  localparam int CORDIC_ITERS = 24;
  localparam int SQRT_ITERS   = 32;

  localparam longint CORDIC_X0 = 64'sd652032874;
  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
  localparam logic [Z_W-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;
  localparam logic [AMP_W-1:0] AMP_MAX = '1;
  localparam logic [BIAS_W-1:0] BIAS_MAX = '1;

  typedef struct packed {
    logic signed [ROM_W-1:0] sn;
    logic signed [ROM_W-1:0] cs;
  } sc_t;

  typedef struct packed {
    logic              acc;
    logic              last;
    logic              init;
    logic              add;
    logic              iter;
    logic [ITER_W-1:0] k;
    logic              clamp;
    logic              mul;
    logic              load;
  } cmd_t;

  function automatic logic [29:0] atan_turn(input logic [ITER_W-1:0] k);
    logic [29:0] r;
    unique case (k)
      5'd0:    r = 30'h20000000;
      5'd1:    r = 30'h12E4051E;
      5'd2:    r = 30'h09FB385B;
      5'd3:    r = 30'h051111D4;
      5'd4:    r = 30'h028B0D43;
      5'd5:    r = 30'h0145D7E1;
      5'd6:    r = 30'h00A2F61E;
      5'd7:    r = 30'h00517C55;
      5'd8:    r = 30'h0028BE53;
      5'd9:    r = 30'h00145F2F;
      5'd10:   r = 30'h000A2F98;
      5'd11:   r = 30'h000517CC;
      5'd12:   r = 30'h00028BE6;
      5'd13:   r = 30'h000145F3;
      5'd14:   r = 30'h0000A2FA;
      5'd15:   r = 30'h0000517D;
      5'd16:   r = 30'h000028BE;
      5'd17:   r = 30'h0000145F;
      5'd18:   r = 30'h00000A30;
      5'd19:   r = 30'h00000518;
      5'd20:   r = 30'h0000028C;
      5'd21:   r = 30'h00000146;
      5'd22:   r = 30'h000000A3;
      5'd23:   r = 30'h00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic longint to_q14(input longint v);
    longint r;
    r = (v + 64'sd32768) >>> 16;
    if (r > 64'sd16384) r = 64'sd16384;
    if (r < -64'sd16384) r = -64'sd16384;
    return r;
  endfunction

  // sine and cosine of a step angle in binary turns, evaluated at elaboration
  function automatic sc_t rom_entry(input logic [31:0] u);
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    longint c0;
    longint s0;
    sc_t    r;
    x = CORDIC_X0;
    y = 64'sd0;
    z = longint'({34'd0, u[29:0]});
    for (int k = 0; k < CORDIC_ITERS; k++) begin
      xs = x >>> k;
      ys = y >>> k;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'({34'd0, atan_turn(ITER_W'(k))});
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'({34'd0, atan_turn(ITER_W'(k))});
      end
    end
    c0 = to_q14(x);
    s0 = to_q14(y);
    unique case (u[31:30])
      2'd0: begin
        r.cs = ROM_W'(c0);
        r.sn = ROM_W'(s0);
      end
      2'd1: begin
        r.cs = ROM_W'(-s0);
        r.sn = ROM_W'(c0);
      end
      2'd2: begin
        r.cs = ROM_W'(-c0);
        r.sn = ROM_W'(-s0);
      end
      2'd3: begin
        r.cs = ROM_W'(s0);
        r.sn = ROM_W'(-c0);
      end
    endcase
    return r;
  endfunction

endpackage

### rtl/nsps_ctrl.sv
module nsps_ctrl #(
  parameter int NUM_STEPS = 8,
  localparam int IDX_W = $clog2(NUM_STEPS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output nsps_pkg::cmd_t    cmd,
  output logic [IDX_W-1:0]  step_idx
);
  import nsps_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ,
    S_SUM,
    S_ITER,
    S_CLAMP,
    S_MUL,
    S_OUT
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  step_r, step_nxt;
  logic [ITER_W-1:0] k_r, k_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              last_step;
  logic              in_xfer;
  logic              load;

  assign last_step = (step_r >= IDX_W'(NUM_STEPS - 1));
  assign in_tready = !(last_step && (state_r != S_IDLE));
  assign in_xfer   = in_tvalid && in_tready;
  assign load      = (state_r == S_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && last_step) state_nxt = S_SQ;
      end
      S_SQ: begin
        state_nxt = S_SUM;
      end
      S_SUM: begin
        state_nxt = S_ITER;
        k_nxt     = '0;
      end
      S_ITER: begin
        k_nxt = k_r + 1'b1;
        if (k_r == ITER_W'(SQRT_ITERS - 1)) state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    step_nxt = step_r;
    if (in_xfer) step_nxt = last_step ? '0 : step_r + 1'b1;

    priority if (load) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign step_idx   = step_r;

  always_comb begin
    cmd.acc   = in_xfer;
    cmd.last  = in_xfer && last_step;
    cmd.init  = (state_r == S_SQ);
    cmd.add   = (state_r == S_SUM);
    cmd.iter  = (state_r == S_ITER);
    cmd.k     = k_r;
    cmd.clamp = (state_r == S_CLAMP);
    cmd.mul   = (state_r == S_MUL);
    cmd.load  = load;
  end

endmodule

### rtl/nsps_dp.sv
module nsps_dp #(
  parameter int NUM_STEPS = 8,
  localparam int IDX_W = $clog2(NUM_STEPS)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  nsps_pkg::cmd_t                  cmd,
  input  logic [IDX_W-1:0]                step_idx,
  input  logic [nsps_pkg::SAMPLE_W-1:0]   sample,
  output logic signed [nsps_pkg::PHASE_W-1:0] phase,
  output logic [nsps_pkg::AMP_W-1:0]      amplitude,
  output logic [nsps_pkg::BIAS_W-1:0]     bias
);
  import nsps_pkg::*;

  localparam int ROM_DEPTH = 2 ** IDX_W;
  localparam int PROD_W    = SAMPLE_W + 1 + ROM_W;
  localparam int DIV_SH    = 22;
  localparam logic [DIV_SH-1:0] DIV_MUL =
    DIV_SH'(((64'd1 << DIV_SH) + 64'(NUM_STEPS) - 64'd1) / 64'(NUM_STEPS));

  // step sine and cosine table
  logic signed [ROM_W-1:0] rom_sn [ROM_DEPTH];
  logic signed [ROM_W-1:0] rom_cs [ROM_DEPTH];

  for (genvar i = 0; i < ROM_DEPTH; i++) begin : g_rom
    localparam sc_t ENT = rom_entry(32'((64'(i) << 32) / NUM_STEPS));
    assign rom_sn[i] = ENT.sn;
    assign rom_cs[i] = ENT.cs;
  end

  // accumulation
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic signed [ACC_W-1:0] sin_acc_r, sin_acc_nxt;
  logic signed [ACC_W-1:0] cos_acc_r, cos_acc_nxt;
  logic signed [PROD_W-1:0] prod_sn, prod_cs;

  assign prod_sn     = $signed({1'b0, sample}) * rom_sn[step_idx];
  assign prod_cs     = $signed({1'b0, sample}) * rom_cs[step_idx];
  assign sum_nxt     = sum_r + SUM_W'(sample);
  assign sin_acc_nxt = sin_acc_r + ACC_W'(prod_sn);
  assign cos_acc_nxt = cos_acc_r + ACC_W'(prod_cs);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r     <= '0;
      sin_acc_r <= '0;
      cos_acc_r <= '0;
    end else if (cmd.acc) begin
      if (cmd.last) begin
        sum_r     <= '0;
        sin_acc_r <= '0;
        cos_acc_r <= '0;
      end else begin
        sum_r     <= sum_nxt;
        sin_acc_r <= sin_acc_nxt;
        cos_acc_r <= cos_acc_nxt;
      end
    end
  end

  // finishing unit
  logic [SUM_W-1:0]        fin_sum_r;
  logic signed [ACC_W-1:0] fin_s_r;
  logic signed [ACC_W-1:0] fin_c_r;
  logic [ABS_W-1:0]        abs_s, abs_c;
  logic [SQ_W-1:0]         sq_s_r, sq_c_r;
  logic [ROOT_W-1:0]       n_r, res_r, bit_r, trial;
  logic signed [CX_W-1:0]  x_r, y_r, xs, ys;
  logic signed [Z_W-1:0]   z_r, atan_k;
  logic                    zero_r;
  logic [QUO_W-1:0]        num_r;
  logic [QUO_W+DIV_SH-1:0] div_prod;
  logic [Z_W-2:0]          zc;
  logic [31:0]             t_r;
  logic [63:0]             ph_prod_r;
  logic [63:0]             ph_round;
  logic [PHASE_W-1:0]      ph_mag;
  logic [32:0]             amp_round;
  logic [QUO_W:0]          amp_full;
  logic                    cordic_step;

  assign abs_s = ABS_W'(fin_s_r[ACC_W-1] ? (ACC_W'(0) - fin_s_r) : fin_s_r);
  assign abs_c = ABS_W'(fin_c_r[ACC_W-1] ? (ACC_W'(0) - fin_c_r) : fin_c_r);

  assign xs     = x_r >>> cmd.k;
  assign ys     = y_r >>> cmd.k;
  assign atan_k = $signed({2'b00, atan_turn(cmd.k)});
  assign trial  = res_r + bit_r;

  // mean by reciprocal multiplication, exact for any 17-bit dividend
  assign div_prod = {{DIV_SH{1'b0}}, num_r} * {{QUO_W{1'b0}}, DIV_MUL};

  assign cordic_step = cmd.iter && (cmd.k < ITER_W'(CORDIC_ITERS)) && !zero_r;

  always_comb begin
    priority if (z_r[Z_W-1]) zc = '0;
    else if (z_r > $signed(QUARTER_TURN)) zc = QUARTER_TURN[Z_W-2:0];
    else zc = z_r[Z_W-2:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.last) begin
      fin_sum_r <= sum_nxt;
      fin_s_r   <= sin_acc_nxt;
      fin_c_r   <= cos_acc_nxt;
    end

    if (cmd.init) begin
      sq_s_r <= abs_s * abs_s;
      sq_c_r <= abs_c * abs_c;
      x_r    <= $signed(CX_W'({abs_s, 16'd0}));
      y_r    <= $signed(CX_W'({abs_c, 16'd0}));
      z_r    <= '0;
      zero_r <= (fin_s_r == '0) && (fin_c_r == '0);
      num_r  <= QUO_W'(fin_sum_r) + QUO_W'(NUM_STEPS / 2);
      res_r  <= '0;
      bit_r  <= ROOT_W'(1) << (ROOT_W - 2);
    end

    if (cmd.add) begin
      n_r   <= ROOT_W'(sq_s_r) + ROOT_W'(sq_c_r);
      num_r <= div_prod[DIV_SH +: QUO_W];
    end

    if (cordic_step) begin
      if (!y_r[CX_W-1]) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atan_k;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atan_k;
      end
    end

    if (cmd.iter) begin
      if (n_r >= trial) begin
        n_r   <= n_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end

    if (cmd.clamp) t_r <= fin_s_r[ACC_W-1] ? (HALF_TURN - {1'b0, zc}) : {1'b0, zc};

    if (cmd.mul) ph_prod_r <= t_r * TWO_PI_Q29;

    if (cmd.load) begin
      phase     <= fin_c_r[ACC_W-1] ? (PHASE_W'(0) - ph_mag) : ph_mag;
      amplitude <= (amp_full > (QUO_W + 1)'(AMP_MAX)) ? AMP_MAX : amp_full[AMP_W-1:0];
      bias      <= (num_r > QUO_W'(BIAS_MAX)) ? BIAS_MAX : num_r[BIAS_W-1:0];
    end
  end

  // round to nearest at the final scaling
  assign ph_round  = ph_prod_r + (64'd1 << 47);
  assign ph_mag    = ph_round[48 +: PHASE_W];
  assign amp_round = {1'b0, res_r[31:0]} + 33'd16384;
  assign amp_full  = amp_round[32:15];

endmodule

### rtl/n_step_phase_shift_demodulator.sv
// n-step phase-shift demodulator for structured-light profilometry
//
// in_*  : one linearized pixel intensity per transfer; NUM_STEPS consecutive
//         transfers are the phase-shifted samples of one pixel
// out_* : one result per pixel with phase (Q3.13 rad), amplitude (Q12.1 at
//         NUM_STEPS = 8) and bias (Q12.0, the rounded mean sample)
//
// samples are taken one per cycle while in_tready is high; each is multiplied
// by the sine and cosine of its step and accumulated. after the last sample of
// a pixel the sums move to a finishing unit: squares, then the bias mean by a
// reciprocal multiply, then 32 iterations of a shared loop that runs the
// vectoring cordic and the square root side by side, then the phase scaling,
// whose result is loaded into the output register.
// the finishing unit holds one pixel; the next pixel's samples keep flowing
// in during that time, and only its last sample waits until the unit is idle.
// the output register holds its result while out_tready is low; the finishing
// unit then waits, and the input backs up behind it.
// synchronous reset clears the step counter, the accumulators and out_tvalid.
module n_step_phase_shift_demodulator #(
  parameter int NUM_STEPS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // sample[11:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // phase[15:0], amplitude[28:16], bias[40:29]
);
  import nsps_pkg::*;

  localparam int IDX_W = $clog2(NUM_STEPS);

  cmd_t                       cmd;
  logic [IDX_W-1:0]           step_idx;
  logic signed [PHASE_W-1:0]  phase;
  logic [AMP_W-1:0]           amplitude;
  logic [BIAS_W-1:0]          bias;

  nsps_ctrl #(
    .NUM_STEPS(NUM_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cmd       (cmd),
    .step_idx  (step_idx)
  );

  nsps_dp #(
    .NUM_STEPS(NUM_STEPS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .step_idx (step_idx),
    .sample   (in_tdata[SAMPLE_W-1:0]),
    .phase    (phase),
    .amplitude(amplitude),
    .bias     (bias)
  );

  assign out_tdata = {7'd0, bias, amplitude, phase};

endmodule

### rtl/nsps_chk.sv
module nsps_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  a_reset_clears_valid: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid set after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[15:0]) <= 16'sd25736) &&
                   ($signed(out_tdata[15:0]) >= -16'sd25736))
    else $error("phase outside +-pi");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[47:41] == 7'd0))
    else $error("nonzero padding in result");

endmodule

bind n_step_phase_shift_demodulator nsps_chk u_nsps_chk (.*);
